/* rtl/core/sdf_pkg.sv */
// shared widths, defaults and types for the sequence duplicate filter
package sdf_pkg;

    localparam int ID_W          = 32;
    localparam int SEQ_W         = 32;
    localparam int ENTRY_W       = ID_W + SEQ_W;
    localparam int TABLE_ENTRIES_DEF = 16;

    typedef struct packed {
        logic is_duplicate;
        logic untracked;
    } t_result;

endpackage

/* rtl/core/sequence_duplicate_filter.sv */
// sequence duplicate filter top level: table walk engine and output register
// a beat's result comes from a walk that reads and compares the filled entries in
// order, stopping at the first id hit, and then passes through the output register;
// one packet in the walk at a time and the next beat is taken in the cycle its
// result beat can leave, so no new beat is taken while a packet is in the walk.
// reset clears the fill count and all handshake state; table contents are kept
module sequence_duplicate_filter #(
    parameter int TABLE_ENTRIES = sdf_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_stall,
    input  logic [sdf_pkg::ID_W-1:0]  i_message_id,
    input  logic [sdf_pkg::SEQ_W-1:0] i_sequence_number,
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic                      o_is_duplicate,
    output logic                      o_untracked
);
    import sdf_pkg::*;

    logic    done;
    logic    take;
    t_result result;
    logic    r_out_valid;
    t_result r_out;

    sdf_engine #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_engine (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_message_id      (i_message_id),
        .i_sequence_number (i_sequence_number),
        .o_done            (done),
        .i_take            (take),
        .o_result          (result)
    );

    // output register frees when empty or when its beat leaves this cycle
    assign take = done && (!r_out_valid || !i_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (take) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_out <= result;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_is_duplicate = r_out.is_duplicate;
    assign o_untracked    = r_out.untracked;

endmodule

/* rtl/core/sdf_ram.sv */
// generic single write port, single read port ram with registered read
module sdf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]  i_wr_data,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* rtl/core/sdf_engine.sv */
// table walk: pipelined read and compare over the filled entries, then update, append or flag untracked
module sdf_engine #(
    parameter int TABLE_ENTRIES = sdf_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_stall,
    input  logic [sdf_pkg::ID_W-1:0]  i_message_id,
    input  logic [sdf_pkg::SEQ_W-1:0] i_sequence_number,
    output logic                      o_done,
    input  logic                      i_take,
    output sdf_pkg::t_result          o_result
);
    import sdf_pkg::*;

    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int FC_W  = $clog2(TABLE_ENTRIES + 1);
    localparam logic [FC_W-1:0] FULL = FC_W'(TABLE_ENTRIES);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_DONE = 3'b100
    } t_state;

    t_state             r_state, n_state;
    logic [FC_W-1:0]    r_fill, n_fill;
    logic [FC_W-1:0]    r_issue, n_issue;
    logic               r_pend, n_pend;
    logic [IDX_W-1:0]   r_cmp_idx, n_cmp_idx;
    logic [ID_W-1:0]    r_ident;
    logic [SEQ_W-1:0]   r_seq;
    t_result            r_res, n_res;

    logic               issue;
    logic [ENTRY_W-1:0] rd_data;
    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    logic               id_hit;
    logic               seq_hit;

    assign issue   = (r_state == S_SCAN) && (r_issue < r_fill);
    assign id_hit  = rd_data[ENTRY_W-1 -: ID_W] == r_ident;
    assign seq_hit = rd_data[SEQ_W-1:0] == r_seq;

    sdf_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data ({r_ident, r_seq}),
        .i_rd_en   (issue),
        .i_rd_addr (r_issue[IDX_W-1:0]),
        .o_rd_data (rd_data)
    );

    always_comb begin
        n_state   = r_state;
        n_fill    = r_fill;
        n_issue   = r_issue;
        n_pend    = 1'b0;
        n_cmp_idx = r_cmp_idx;
        n_res     = r_res;
        wr_en     = 1'b0;
        wr_addr   = r_cmp_idx;
        case (r_state)
            S_IDLE: begin
                n_issue = '0;
                if (i_valid) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                // read of the next entry overlaps the compare of the last one
                n_pend    = issue;
                n_cmp_idx = r_issue[IDX_W-1:0];
                if (issue) begin
                    n_issue = r_issue + 1'b1;
                end
                if (r_pend && id_hit) begin
                    n_pend  = 1'b0;
                    n_state = S_DONE;
                    n_res   = '{is_duplicate: seq_hit, untracked: 1'b0};
                    wr_en   = !seq_hit;
                    wr_addr = r_cmp_idx;
                end else if (!r_pend && !issue) begin
                    // walked every filled entry without a hit
                    n_state = S_DONE;
                    if (r_fill < FULL) begin
                        wr_en   = 1'b1;
                        wr_addr = r_fill[IDX_W-1:0];
                        n_fill  = r_fill + 1'b1;
                        n_res   = '{is_duplicate: 1'b0, untracked: 1'b0};
                    end else begin
                        n_res   = '{is_duplicate: 1'b0, untracked: 1'b1};
                    end
                end
            end
            S_DONE: begin
                if (i_take) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_fill  <= '0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            r_pend  <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_issue   <= n_issue;
        r_cmp_idx <= n_cmp_idx;
        r_res     <= n_res;
        if (r_state == S_IDLE && i_valid) begin
            r_ident <= i_message_id;
            r_seq   <= i_sequence_number;
        end
    end

    assign o_stall  = r_state != S_IDLE;
    assign o_done   = r_state == S_DONE;
    assign o_result = r_res;

endmodule
